// File: sv/box_mean_blur_filter_core_defines.svh
// Assertion macros shared by the checker of the box mean blur filter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BOX_MEAN_BLUR_FILTER_CORE_DEFINES_SVH
`define BOX_MEAN_BLUR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box mean filter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box mean filter check failed");

`endif

// File: sv/bmb_pkg.sv
// Package of the box mean blur filter: sequencer states and register codes.
// Depends on nothing; imported by the filter modules.
`timescale 1ns / 1ps
`default_nettype none

package bmb_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WIN,
        S_RD,
        S_AC,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } t_state;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_WIDTH    = 2'd0;
    localparam t_reg_idx REG_HEIGHT   = 2'd1;
    localparam t_reg_idx REG_RADIUS_X = 2'd2;
    localparam t_reg_idx REG_RADIUS_Y = 2'd3;

    localparam logic [10:0] RST_WIDTH    = 11'd1024;
    localparam logic [10:0] RST_HEIGHT   = 11'd1024;
    localparam logic [2:0]  RST_RADIUS_X = 3'd1;
    localparam logic [2:0]  RST_RADIUS_Y = 3'd1;

    localparam int QUOT_W = 8;

endpackage

`default_nettype wire

// File: sv/bmb_line_mem.sv
// Line store of the box mean blur filter: one write port and one read port.
// Depends on nothing; the read data is registered.
`timescale 1ns / 1ps
`default_nettype none

module bmb_line_mem #(
    parameter int DEPTH = 15360,
    parameter int AW    = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/bmb_div.sv
// Restoring divider of the box mean blur filter, one quotient bit a cycle.
// Depends on bmb_pkg for the quotient width.
`timescale 1ns / 1ps
`default_nettype none

module bmb_div #(
    parameter int DVW = 18
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [DVW-1:0]            i_num,
    input  wire logic [DVW-1:0]            i_den,
    output logic                           o_done,
    output logic [bmb_pkg::QUOT_W-1:0]     o_quot
);
    import bmb_pkg::*;

    localparam int SCW = $clog2(QUOT_W);

    logic [DVW+QUOT_W-1:0] r_rem;
    logic [DVW+QUOT_W-1:0] r_d;
    logic [SCW-1:0]        r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [QUOT_W-1:0]     r_q;
    logic                  ge;

    assign ge = (r_rem >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SCW'(1);
                if (r_step == SCW'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DVW+QUOT_W)'(i_num);
            r_d   <= (DVW+QUOT_W)'(i_den) << (QUOT_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_d;
            end
            r_q <= {r_q[QUOT_W-2:0], ge};
            r_d <= r_d >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: sv/box_mean_blur_filter_core.sv
// Box mean blur filter with edge clipping: one item is one raster pixel, and
// each result is the rounded mean of the clipped window around an earlier pixel.
// The sequencer accepts one item at a time; each item passes through S_IDLE and S_SETUP,
// then for every result it causes (up to eight) S_WIN, an S_RD and S_AC pair per window
// pixel read from the line store, S_DIV_GO and S_DIV for the bit-serial divider, and S_OUT
// until the consumer accepts the result.
// Depends on bmb_pkg, bmb_line_mem and bmb_div.
`timescale 1ns / 1ps
`default_nettype none

module box_mean_blur_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_pixel_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [7:0]  o_mean_level,
    output logic      [9:0]  o_out_col,
    output logic      [9:0]  o_out_row,
    output logic             o_frame_done,
    output logic             o_run_last
);
    import bmb_pkg::*;

    localparam int SLOTS  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = SLOTS * MAX_WIDTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
    localparam int YW     = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
    localparam int RW     = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int MAXCNT = SLOTS * SLOTS;
    localparam int CNTW   = $clog2(MAXCNT + 1);
    localparam int SUMW   = $clog2(MAXCNT * 255 + 1);
    localparam int DVW    = SUMW + 2;

    t_state r_state, n_state;

    logic [10:0] r_cfg_w, r_cfg_h;
    logic [2:0]  r_cfg_rx, r_cfg_ry;

    logic [CW-1:0] w_eff;
    logic [YW-1:0] h_eff;
    logic [RW-1:0] rx_eff, ry_eff;

    logic [CW-1:0] r_scan_col;
    logic [YW-1:0] r_scan_row;
    logic [SW-1:0] r_scan_slot;

    logic [CW-1:0] col_e, c0_a, c1_a;
    logic [YW-1:0] row_e, h_pad, row_nx;
    logic [SW-1:0] slot_e, slot_nx;
    logic          wrap, row_end, col_ok, any_a, cfg_wr, in_acc, out_acc;

    logic [YW-1:0] r_row_e, r_r, r_y0, r_y1, r_y;
    logic [SW-1:0] r_slot_e, r_y0slot, r_slot;
    logic [CW-1:0] r_c, r_c1, r_x0, r_x1, r_x;
    logic          r_any;
    logic [SUMW-1:0] r_sum;
    logic [CNTW-1:0] r_cnt;

    logic [YW-1:0] y0_s, y1_s, d_s;
    logic [SW-1:0] d_sl, y0slot_s;
    logic [CW-1:0] x0_s, x1_s;

    logic [7:0]          rd_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                wr_en;
    logic                div_start, div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic [DVW-1:0]      div_num, div_den;

    // Effective configuration after clipping to the supported range.
    assign w_eff  = (r_cfg_w == '0) ? CW'(1) :
                    ((32'(r_cfg_w) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(r_cfg_w));
    assign h_eff  = (r_cfg_h == '0) ? YW'(1) :
                    ((32'(r_cfg_h) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(r_cfg_h));
    assign rx_eff = (32'(r_cfg_rx) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_cfg_rx);
    assign ry_eff = (32'(r_cfg_ry) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_cfg_ry);

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_WIDTH:    prdata = {21'd0, r_cfg_w};
            REG_HEIGHT:   prdata = {21'd0, r_cfg_h};
            REG_RADIUS_X: prdata = {29'd0, r_cfg_rx};
            REG_RADIUS_Y: prdata = {29'd0, r_cfg_ry};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= RST_WIDTH;
            r_cfg_h  <= RST_HEIGHT;
            r_cfg_rx <= RST_RADIUS_X;
            r_cfg_ry <= RST_RADIUS_Y;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_WIDTH:    r_cfg_w  <= pwdata[10:0];
                REG_HEIGHT:   r_cfg_h  <= pwdata[10:0];
                REG_RADIUS_X: r_cfg_rx <= pwdata[2:0];
                REG_RADIUS_Y: r_cfg_ry <= pwdata[2:0];
                default:      r_cfg_w  <= r_cfg_w;
            endcase
        end
    end

    // Position of the arriving item and the result columns it releases.
    assign col_e   = (r_scan_col >= w_eff) ? (w_eff - CW'(1)) : r_scan_col;
    assign h_pad   = h_eff + YW'(ry_eff);
    assign wrap    = (r_scan_row >= h_pad);
    assign row_e   = wrap ? '0 : r_scan_row;
    assign slot_e  = wrap ? '0 : r_scan_slot;
    assign row_end = (col_e == (w_eff - CW'(1)));
    assign col_ok  = (col_e >= CW'(rx_eff));
    assign c0_a    = col_ok ? (col_e - CW'(rx_eff)) : '0;
    assign c1_a    = row_end ? (w_eff - CW'(1)) : c0_a;
    assign any_a   = (row_e >= YW'(ry_eff)) && ((row_e - YW'(ry_eff)) < h_eff)
                     && (row_end || col_ok);
    assign row_nx  = row_e + YW'(1);
    assign slot_nx = (slot_e == SW'(SLOTS - 1)) ? '0 : (slot_e + SW'(1));

    assign in_acc  = i_valid & o_ready;
    assign out_acc = o_valid & i_ready;

    assign wr_en   = in_acc && (row_e < h_eff);
    assign wr_addr = AW'(32'(slot_e) * MAX_WIDTH + 32'(col_e));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col  <= '0;
            r_scan_row  <= '0;
            r_scan_slot <= '0;
        end else if (cfg_wr) begin
            r_scan_col  <= '0;
            r_scan_row  <= '0;
            r_scan_slot <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_scan_col <= '0;
                if (row_nx >= h_pad) begin
                    r_scan_row  <= '0;
                    r_scan_slot <= '0;
                end else begin
                    r_scan_row  <= row_nx;
                    r_scan_slot <= slot_nx;
                end
            end else begin
                r_scan_col <= col_e + CW'(1);
                r_scan_row <= row_e;
                r_scan_slot <= slot_e;
            end
        end
    end

    // Window bounds, rows once per item and columns once per result.
    assign y0_s     = (r_r >= YW'(ry_eff)) ? (r_r - YW'(ry_eff)) : '0;
    assign y1_s     = (r_row_e < h_eff) ? r_row_e : (h_eff - YW'(1));
    assign d_s      = r_row_e - y0_s;
    assign d_sl     = SW'(d_s);
    assign y0slot_s = (r_slot_e >= d_sl) ? (r_slot_e - d_sl)
                                         : (r_slot_e + SW'(SLOTS) - d_sl);
    assign x0_s     = (r_c >= CW'(rx_eff)) ? (r_c - CW'(rx_eff)) : '0;
    assign x1_s     = ((r_c + CW'(rx_eff)) < w_eff) ? (r_c + CW'(rx_eff))
                                                    : (w_eff - CW'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_SETUP;
            S_SETUP:  n_state = r_any ? S_WIN : S_IDLE;
            S_WIN:    n_state = S_RD;
            S_RD:     n_state = S_AC;
            S_AC:     n_state = ((r_x == r_x1) && (r_y == r_y1)) ? S_DIV_GO : S_RD;
            S_DIV_GO: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = (r_c == r_c1) ? S_IDLE : S_WIN;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE:   o_ready   = 1'b1;
            S_RD:     rd_en     = 1'b1;
            S_DIV_GO: div_start = 1'b1;
            S_OUT:    o_valid   = 1'b1;
            default:  o_ready   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_row_e  <= row_e;
                r_slot_e <= slot_e;
                r_r      <= row_e - YW'(ry_eff);
                r_c      <= c0_a;
                r_c1     <= c1_a;
                r_any    <= any_a;
            end
            S_SETUP: begin
                r_y0     <= y0_s;
                r_y1     <= y1_s;
                r_y0slot <= y0slot_s;
            end
            S_WIN: begin
                r_x0   <= x0_s;
                r_x1   <= x1_s;
                r_x    <= x0_s;
                r_y    <= r_y0;
                r_slot <= r_y0slot;
                r_sum  <= '0;
                r_cnt  <= '0;
            end
            S_AC: begin
                r_sum <= r_sum + SUMW'(rd_data);
                r_cnt <= r_cnt + CNTW'(1);
                if (r_x == r_x1) begin
                    r_x <= r_x0;
                    r_y <= r_y + YW'(1);
                    r_slot <= (r_slot == SW'(SLOTS - 1)) ? '0 : (r_slot + SW'(1));
                end else begin
                    r_x <= r_x + CW'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    o_mean_level <= div_quot;
                    o_out_col    <= 10'(r_c);
                    o_out_row    <= 10'(r_r);
                    o_frame_done <= (r_r == (h_eff - YW'(1))) && (r_c == (w_eff - CW'(1)));
                    o_run_last   <= (r_c == r_c1);
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    r_c <= r_c + CW'(1);
                end
            end
            default: r_any <= r_any;
        endcase
    end

    assign rd_addr = AW'(32'(r_slot) * MAX_WIDTH + 32'(r_x));
    assign div_num = {r_sum, 1'b0} + DVW'(r_cnt);
    assign div_den = DVW'({r_cnt, 1'b0});

    bmb_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_pixel_in),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bmb_div #(
        .DVW (DVW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

`default_nettype wire

// File: sv/bmb_checker.sv
// Port-level checker of the box mean blur filter and its bind to the top level.
// Depends on box_mean_blur_filter_core_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "box_mean_blur_filter_core_defines.svh"

module bmb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_mean_level,
    input wire logic       o_frame_done,
    input wire logic       o_run_last
);

    // A waiting result keeps its value until it is taken.
    `BMB_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_mean_level))

    // No new item is taken while a result is still on offer.
    `BMB_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !o_ready)

    // The last pixel of a frame always closes its run.
    `BMB_ASSERT_IMP(a_done_last, i_clk, i_rst_n, o_valid && o_frame_done, o_run_last)

    // Once the final result of an item is taken, the block is ready again.
    `BMB_ASSERT_NXT(a_ready_after, i_clk, i_rst_n, o_valid && i_ready && o_run_last, o_ready)

endmodule

bind box_mean_blur_filter_core bmb_checker u_bmb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_mean_level (o_mean_level),
    .o_frame_done (o_frame_done),
    .o_run_last   (o_run_last)
);

`default_nettype wire

// File: dv/box_mean_blur_filter_core_tb.sv
// Self-checking testbench for box_mean_blur_filter_core: a directed table, then
// random frames under several idling patterns, checked against a local predictor.
// Depends on bmb_pkg and box_mean_blur_filter_core.
`timescale 1ns / 1ps

module box_mean_blur_filter_core_tb;
    import bmb_pkg::*;

    localparam int STORE_ROWS = 15;
    localparam int STORE_COLS = 1024;
    localparam int WDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS = 350;

    typedef struct packed {
        logic [7:0] mean;
        logic [9:0] col;
        logic [9:0] row;
        logic       done;
        logic       last;
    } blur_px_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_EXP} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        t_reg_idx    idx;
        logic [31:0] val;
        logic [7:0]  exp_mean;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_pixel_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_mean_level;
    logic [9:0]  o_out_col;
    logic [9:0]  o_out_row;
    logic        o_frame_done;
    logic        o_run_last;

    box_mean_blur_filter_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_pixel_in(i_pixel_in),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_mean_level(o_mean_level), .o_out_col(o_out_col), .o_out_row(o_out_row),
        .o_frame_done(o_frame_done), .o_run_last(o_run_last)
    );

    always #5 i_clk = ~i_clk;

    logic [7:0]  blur_rows [STORE_ROWS][STORE_COLS];
    int unsigned scan_col, scan_row;
    int unsigned frame_w_reg, frame_h_reg, rad_x_reg, rad_y_reg;
    blur_px_t    pending_means [$];
    stim_row_t   stim_tab [$];
    bit          failed = 1'b0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        blur_px_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_mean_level, o_out_col, o_out_row, o_frame_done, o_run_last};
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, got);
                failed = 1'b1;
            end else begin
                want = pending_means.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WDOG_LIMIT) begin
            $display("box_mean_blur_filter_core verification failed");
            $finish;
        end
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo,
                                            int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] clipped_mean(int unsigned r, int unsigned c,
                                                int unsigned w, int unsigned h,
                                                int unsigned rx, int unsigned ry);
        int unsigned y0, y1, x0, x1, acc, cnt;
        y0 = (r >= ry) ? r - ry : 0;
        y1 = (r + ry < h) ? r + ry : h - 1;
        x0 = (c >= rx) ? c - rx : 0;
        x1 = (c + rx < w) ? c + rx : w - 1;
        acc = 0;
        cnt = 0;
        for (int unsigned y = y0; y <= y1; y++) begin
            for (int unsigned x = x0; x <= x1; x++) begin
                acc += blur_rows[y % STORE_ROWS][x];
                cnt++;
            end
        end
        return 8'((2 * acc + cnt) / (2 * cnt));
    endfunction

    task automatic predict_means(logic [7:0] pix);
        int unsigned w, h, rx, ry, col, row, r, c0, c1, n;
        bit row_end, any;
        w = clamp_u(frame_w_reg, 1, STORE_COLS);
        h = clamp_u(frame_h_reg, 1, 1024);
        rx = clamp_u(rad_x_reg, 0, 7);
        ry = clamp_u(rad_y_reg, 0, 7);
        col = scan_col;
        row = scan_row;
        n = 0;
        if (col >= w) col = w - 1;
        if (row >= h + ry) row = 0;
        row_end = (col == w - 1);
        if (row < h) blur_rows[row % STORE_ROWS][col] = pix;
        if (row >= ry) begin
            r = row - ry;
            any = 1'b1;
            c0 = 0;
            c1 = 0;
            if (row_end) begin
                c0 = (col >= rx) ? col - rx : 0;
                c1 = w - 1;
            end else if (col >= rx) begin
                c0 = col - rx;
                c1 = c0;
            end else begin
                any = 1'b0;
            end
            if (any && r < h) begin
                for (int unsigned c = c0; c <= c1 && n < 8; c++) begin
                    pending_means.push_back(blur_px_t'{clipped_mean(r, c, w, h, rx, ry),
                        10'(c), 10'(r), (r == h - 1 && c == w - 1), (c == c1)});
                    n++;
                end
            end
        end
        if (row_end) begin
            col = 0;
            row++;
            if (row >= h + ry) row = 0;
        end else begin
            col++;
        end
        scan_col = col;
        scan_row = row;
    endtask

    task automatic drain_results();
        while (pending_means.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:    frame_w_reg = val & 32'h7FF;
            REG_HEIGHT:   frame_h_reg = val & 32'h7FF;
            REG_RADIUS_X: rad_x_reg = val & 32'h7;
            REG_RADIUS_Y: rad_y_reg = val & 32'h7;
            default: ;
        endcase
        scan_col = 0;
        scan_row = 0;
    endtask

    // A pause lowers valid first, so valid is never lowered and raised in one step.
    task automatic send_pixel(logic [7:0] pix);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_ready);
        predict_means(pix);
    endtask

    task automatic add_row(row_kind_t kind, t_reg_idx idx, logic [31:0] val,
                           logic [7:0] exp_mean);
        stim_tab.push_back(stim_row_t'{kind, idx, val, exp_mean});
    endtask

    function automatic logic [31:0] pick_size(int unsigned hi);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd2047;
            2: return 32'd1024;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    initial begin
        int unsigned sent, seg, n, flen, w, h, ry;
        frame_w_reg = RST_WIDTH;
        frame_h_reg = RST_HEIGHT;
        rad_x_reg = RST_RADIUS_X;
        rad_y_reg = RST_RADIUS_Y;
        scan_col = 0;
        scan_row = 0;

        add_row(ROW_PIX, REG_WIDTH, 32'd0, 8'd0);
        add_row(ROW_PIX, REG_WIDTH, 32'd255, 8'd0);
        add_row(ROW_CFG, REG_WIDTH, 32'd1, 8'd0);
        add_row(ROW_CFG, REG_HEIGHT, 32'd1, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_X, 32'd0, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_Y, 32'd0, 8'd0);
        add_row(ROW_PIX_EXP, REG_WIDTH, 32'd255, 8'd255);
        add_row(ROW_PIX_EXP, REG_WIDTH, 32'd0, 8'd0);
        add_row(ROW_CFG, REG_WIDTH, 32'd0, 8'd0);
        add_row(ROW_CFG, REG_HEIGHT, 32'd0, 8'd0);
        add_row(ROW_PIX_EXP, REG_WIDTH, 32'hA5, 8'hA5);
        add_row(ROW_CFG, REG_WIDTH, 32'd2047, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_X, 32'd7, 8'd0);
        for (int i = 0; i < 10; i++) add_row(ROW_PIX, REG_WIDTH, (i % 2) ? 0 : 255, 8'd0);
        add_row(ROW_CFG, REG_WIDTH, 32'd1, 8'd0);
        add_row(ROW_CFG, REG_HEIGHT, 32'd2047, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_X, 32'd0, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_Y, 32'd7, 8'd0);
        for (int i = 0; i < 8; i++) add_row(ROW_PIX, REG_WIDTH, 32'd255 - i, 8'd0);
        add_row(ROW_CFG, REG_WIDTH, 32'd2, 8'd0);
        add_row(ROW_CFG, REG_HEIGHT, 32'd1, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_X, 32'd1, 8'd0);
        add_row(ROW_CFG, REG_RADIUS_Y, 32'd1, 8'd0);
        for (int i = 0; i < 6; i++) add_row(ROW_PIX, REG_WIDTH, 32'd40 * i, 8'd0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_tab[k]) begin
            case (stim_tab[k].kind)
                ROW_CFG: write_reg(stim_tab[k].idx, stim_tab[k].val);
                ROW_PIX: send_pixel(stim_tab[k].val[7:0]);
                default: begin
                    send_pixel(stim_tab[k].val[7:0]);
                    void'(pending_means.pop_back());
                    pending_means.push_back(blur_px_t'{stim_tab[k].exp_mean, 10'd0,
                                                       10'd0, 1'b1, 1'b1});
                end
            endcase
        end

        sent = 0;
        seg = 0;
        while (sent < RANDOM_ITEMS) begin
            case (seg % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 76; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 76; end
                default: begin sender_idle_pct = 25; stall_pct = 25; end
            endcase
            write_reg(REG_WIDTH, pick_size(12));
            write_reg(REG_HEIGHT, pick_size(5));
            write_reg(REG_RADIUS_X, $urandom_range(0, 7));
            write_reg(REG_RADIUS_Y, $urandom_range(0, 7));
            w = clamp_u(frame_w_reg, 1, 1024);
            h = clamp_u(frame_h_reg, 1, 1024);
            ry = rad_y_reg;
            flen = w * (h + ry);
            n = (flen <= 60) ? flen * $urandom_range(1, 2) + $urandom_range(0, 3)
                             : $urandom_range(15, 50);
            if (sent + n > RANDOM_ITEMS) n = RANDOM_ITEMS - sent;
            for (int unsigned i = 0; i < n; i++) begin
                if ((seg == 1 && i == n / 2) || $urandom_range(0, 59) == 0) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    drain_results();
                end
                send_pixel($urandom_range(0, 255));
            end
            sent += n;
            seg++;
        end

        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!failed && pending_means.size() == 0) begin
            $display("box_mean_blur_filter_core verification clean");
        end else begin
            $display("box_mean_blur_filter_core verification failed");
        end
        $finish;
    end

endmodule
